[rtl/tmcv_pkg.sv]
// Shared types, register map, error codes and format tables of the mip chain validator.
package tmcv_pkg;

   localparam int MAX_MIP_LEVELS = 16;
   localparam int FORMAT_COUNT   = 17;
   localparam int CSR_AW         = 5;
   localparam int CSR_DW         = 32;

   // register indexes, at byte address 4*index
   localparam logic [2:0] REG_TEX_WIDTH     = 3'd0;
   localparam logic [2:0] REG_TEX_HEIGHT    = 3'd1;
   localparam logic [2:0] REG_LAYER_COUNT   = 3'd2;
   localparam logic [2:0] REG_MIP_LEVELS    = 3'd3;
   localparam logic [2:0] REG_FORMAT_CODE   = 3'd4;
   localparam logic [2:0] REG_ASSET_FLAGS   = 3'd5;
   localparam logic [2:0] REG_CSPACE        = 3'd6;
   localparam logic [2:0] REG_CHANNEL_COUNT = 3'd7;

   localparam logic [3:0] ERR_NONE     = 4'd0;
   localparam logic [3:0] ERR_HEADER   = 4'd1;
   localparam logic [3:0] ERR_FLAG_FMT = 4'd2;
   localparam logic [3:0] ERR_CHANNELS = 4'd3;
   localparam logic [3:0] ERR_OFFSET   = 4'd4;
   localparam logic [3:0] ERR_SIZE     = 4'd5;
   localparam logic [3:0] ERR_EXTENT   = 4'd6;
   localparam logic [3:0] ERR_COUNT    = 4'd7;
   localparam logic [3:0] ERR_PAYLOAD  = 4'd8;

   localparam logic [1:0] TILE_1 = 2'd0;
   localparam logic [1:0] TILE_4 = 2'd1;
   localparam logic [1:0] TILE_6 = 2'd2;

   // ceil(x/6) = ((x+5) * RECIP6) >> RECIP6_SHIFT, exact for x+5 < 2^17
   localparam logic [15:0] RECIP6       = 16'd43691;
   localparam int          RECIP6_SHIFT = 18;

   typedef struct packed {
      logic [47:0] mip_offset;
      logic [47:0] mip_size;
      logic [15:0] mip_width;
      logic [15:0] mip_height;
      logic [47:0] payload_bytes;
      logic        last_entry;
   } req_word_type;

   typedef struct packed {
      logic       level_ok;
      logic [3:0] error_code;
      logic       verdict_valid;
      logic       verdict_ready;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] tex_width;
      logic [15:0] tex_height;
      logic [11:0] layer_count;
      logic [4:0]  mip_levels;
      logic [4:0]  format_code;
      logic [7:0]  asset_flags;
      logic [2:0]  cspace;
      logic [3:0]  channel_count;
   } cfg_type;

   typedef struct packed {
      logic [1:0] tile;
      logic [2:0] bytes_log2;
      logic [3:0] chans;
      logic       packed_fmt;
   } shape_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // take a word and run the tile step
      logic mult;     // tile product
      logic scale;    // bytes and layers
      logic commit;   // checks, state update, result register
   } cmd_type;

   function automatic shape_type shape_of(input logic [4:0] fmt);
      shape_type s;
      case (fmt)
         5'd0, 5'd1:                  s = '{TILE_1, 3'd2, 4'd4, 1'b0};
         5'd2:                        s = '{TILE_1, 3'd1, 4'd2, 1'b0};
         5'd3:                        s = '{TILE_1, 3'd0, 4'd1, 1'b0};
         5'd4:                        s = '{TILE_1, 3'd3, 4'd4, 1'b0};
         5'd5, 5'd6, 5'd7:            s = '{TILE_4, 3'd3, 4'd4, 1'b1};
         5'd8, 5'd9, 5'd10, 5'd11,
         5'd13, 5'd14:                s = '{TILE_4, 3'd4, 4'd4, 1'b1};
         5'd12:                       s = '{TILE_4, 3'd4, 4'd2, 1'b1};
         5'd15, 5'd16:                s = '{TILE_6, 3'd4, 4'd4, 1'b1};
         default:                     s = '{TILE_1, 3'd2, 4'd4, 1'b0};
      endcase
      return s;
   endfunction

endpackage

[rtl/tmcv_csr.sv]
// Header register file behind the APB-style port.
module tmcv_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tmcv_pkg::CSR_AW-1:0]    paddr,
   input  logic [tmcv_pkg::CSR_DW-1:0]    pwdata,
   output logic [tmcv_pkg::CSR_DW-1:0]    prdata,
   output logic                           pready,
   output tmcv_pkg::cfg_type              cfg
);
   import tmcv_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_TEX_WIDTH:     cfg_in.tex_width     = pwdata[15:0];
            REG_TEX_HEIGHT:    cfg_in.tex_height    = pwdata[15:0];
            REG_LAYER_COUNT:   cfg_in.layer_count   = pwdata[11:0];
            REG_MIP_LEVELS:    cfg_in.mip_levels    = pwdata[4:0];
            REG_FORMAT_CODE:   cfg_in.format_code   = pwdata[4:0];
            REG_ASSET_FLAGS:   cfg_in.asset_flags   = pwdata[7:0];
            REG_CSPACE:        cfg_in.cspace        = pwdata[2:0];
            REG_CHANNEL_COUNT: cfg_in.channel_count = pwdata[3:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TEX_WIDTH:     prdata = {16'd0, cfg_ff.tex_width};
         REG_TEX_HEIGHT:    prdata = {16'd0, cfg_ff.tex_height};
         REG_LAYER_COUNT:   prdata = {20'd0, cfg_ff.layer_count};
         REG_MIP_LEVELS:    prdata = {27'd0, cfg_ff.mip_levels};
         REG_FORMAT_CODE:   prdata = {27'd0, cfg_ff.format_code};
         REG_ASSET_FLAGS:   prdata = {24'd0, cfg_ff.asset_flags};
         REG_CSPACE:        prdata = {29'd0, cfg_ff.cspace};
         REG_CHANNEL_COUNT: prdata = {28'd0, cfg_ff.channel_count};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/tmcv_ctrl.sv]
// Sequencer: accept, tile product, scaling, commit; owns the result valid.
module tmcv_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tmcv_pkg::cmd_type cmd
);
   import tmcv_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MULT   = 2'd1;
   localparam logic [1:0] ST_SCALE  = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   // result slot free now or emptied at this edge
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/tmcv_dp.sv]
// Datapath: expected level geometry and size, entry checks, chain state, result register.
module tmcv_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  tmcv_pkg::cfg_type      cfg,
   input  tmcv_pkg::cmd_type      cmd,
   input  tmcv_pkg::req_word_type req_data,
   output tmcv_pkg::rsp_word_type rsp_data
);
   import tmcv_pkg::*;

   req_word_type item_ff;
   rsp_word_type rsp_ff, rsp_in;
   logic [3:0]   hdr_err_ff, hdr_err;
   logic [15:0]  w_ff, h_ff, bx_ff, by_ff, bx, by;
   logic [2:0]   blog_ff;
   logic [31:0]  prod_ff;
   logic [47:0]  expect_ff;
   logic [4:0]   level_ff, level_in;
   logic [47:0]  run_off_ff, run_off_in;
   logic [3:0]   first_err_ff, first_err_in;

   shape_type    shape;
   logic [15:0]  w_sh, h_sh, w_lvl, h_lvl;
   logic [16:0]  w_pad, h_pad;
   logic [33:0]  w_rec, h_rec;
   logic [35:0]  scaled;
   logic [47:0]  new_off;
   logic [3:0]   err;
   logic         ok;

   assign shape = shape_of(cfg.format_code);

   always_comb begin
      hdr_err = ERR_NONE;
      if (cfg.tex_width == '0 || cfg.tex_height == '0 || cfg.layer_count == '0 ||
          cfg.mip_levels == '0 || cfg.mip_levels > 5'(MAX_MIP_LEVELS) ||
          cfg.cspace > 3'd2 || cfg.asset_flags[7:3] != '0 ||
          cfg.format_code >= 5'(FORMAT_COUNT)) begin
         hdr_err = ERR_HEADER;
      end else if (cfg.asset_flags[0] != shape.packed_fmt ||
                   (cfg.asset_flags[2] && cfg.mip_levels != 5'd1)) begin
         hdr_err = ERR_FLAG_FMT;
      end else if (cfg.channel_count != shape.chans) begin
         hdr_err = ERR_CHANNELS;
      end
   end

   // level extents, clamped to one
   always_comb begin
      w_sh  = cfg.tex_width >> level_ff;
      h_sh  = cfg.tex_height >> level_ff;
      w_lvl = (w_sh == '0) ? 16'd1 : w_sh;
      h_lvl = (h_sh == '0) ? 16'd1 : h_sh;
   end

   // tile counts: ceil by 1, 4 or 6
   always_comb begin
      w_pad = {1'b0, w_lvl};
      h_pad = {1'b0, h_lvl};
      case (shape.tile)
         TILE_4: begin
            w_pad = {1'b0, w_lvl} + 17'd3;
            h_pad = {1'b0, h_lvl} + 17'd3;
         end
         TILE_6: begin
            w_pad = {1'b0, w_lvl} + 17'd5;
            h_pad = {1'b0, h_lvl} + 17'd5;
         end
         default: begin
            w_pad = {1'b0, w_lvl};
            h_pad = {1'b0, h_lvl};
         end
      endcase
      w_rec = 34'(w_pad) * 34'(RECIP6);
      h_rec = 34'(h_pad) * 34'(RECIP6);
      case (shape.tile)
         TILE_4: begin
            bx = {1'b0, w_pad[17-1:2]};
            by = {1'b0, h_pad[17-1:2]};
         end
         TILE_6: begin
            bx = w_rec[RECIP6_SHIFT+15:RECIP6_SHIFT];
            by = h_rec[RECIP6_SHIFT+15:RECIP6_SHIFT];
         end
         default: begin
            bx = w_lvl;
            by = h_lvl;
         end
      endcase
   end

   assign scaled = 36'(prod_ff) << blog_ff;

   always_comb begin
      err          = hdr_err_ff;
      new_off      = run_off_ff + expect_ff;
      run_off_in   = run_off_ff;
      level_in     = (level_ff == 5'd31) ? level_ff : level_ff + 5'd1;
      if (hdr_err_ff == ERR_NONE) begin
         if (level_ff >= cfg.mip_levels) begin
            err = ERR_COUNT;
         end else if (item_ff.mip_offset != run_off_ff) begin
            err = ERR_OFFSET;
         end else if (item_ff.mip_size != expect_ff) begin
            err = ERR_SIZE;
         end else if (item_ff.mip_width != w_ff || item_ff.mip_height != h_ff) begin
            err = ERR_EXTENT;
         end
         run_off_in = new_off;
         if (err == ERR_NONE && first_err_ff == ERR_NONE && item_ff.last_entry) begin
            if ({1'b0, level_ff} + 6'd1 != {1'b0, cfg.mip_levels}) begin
               err = ERR_COUNT;
            end else if (new_off != item_ff.payload_bytes) begin
               err = ERR_PAYLOAD;
            end
         end
      end
      first_err_in = (first_err_ff == ERR_NONE) ? err : first_err_ff;
      ok           = (first_err_in == ERR_NONE);
      rsp_in.level_ok      = ok;
      rsp_in.error_code    = first_err_in;
      rsp_in.verdict_valid = ok & item_ff.last_entry;
      rsp_in.verdict_ready = item_ff.last_entry;
      // last word closes the texture
      if (item_ff.last_entry) begin
         level_in     = '0;
         run_off_in   = '0;
         first_err_in = ERR_NONE;
      end
   end

   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         run_off_ff   <= '0;
         first_err_ff <= ERR_NONE;
      end else if (cmd.commit) begin
         level_ff     <= level_in;
         run_off_ff   <= run_off_in;
         first_err_ff <= first_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff    <= req_data;
         hdr_err_ff <= hdr_err;
         w_ff       <= w_lvl;
         h_ff       <= h_lvl;
         bx_ff      <= bx;
         by_ff      <= by;
         blog_ff    <= shape.bytes_log2;
      end
      if (cmd.mult) begin
         prod_ff <= 32'(bx_ff) * 32'(by_ff);
      end
      if (cmd.scale) begin
         expect_ff <= 48'(scaled) * 48'(cfg.layer_count);
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

[rtl/texture_mip_chain_validator.sv]
// Top level of the texture mip chain validator.
// Checks a texture header held in eight registers (width, height, layers, mip
// count, format, flags, color space, channels) and then the mip table, one
// entry per input word in level order. Each word yields one result word with
// the sticky first error; the word flagged last carries the verdict and
// restarts the chain. An entry runs from acceptance to result in order: the
// accept step works out level extents and tile counts, then come the tile
// product, the byte and layer scaling multiply, and the checks and offset
// update, held while an unaccepted result waits. A finished result waits in
// its output register while the next word is accepted. Header registers are
// to be written only while no entry is in flight; the block does not enforce it.
module texture_mip_chain_validator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  tmcv_pkg::req_word_type         req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tmcv_pkg::rsp_word_type         rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [tmcv_pkg::CSR_AW-1:0]    paddr,
   input  logic [tmcv_pkg::CSR_DW-1:0]    pwdata,
   output logic [tmcv_pkg::CSR_DW-1:0]    prdata,
   output logic                           pready
);
   import tmcv_pkg::*;

   cfg_type cfg;
   cmd_type cmd;

   tmcv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tmcv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   tmcv_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
